// ----- src/blpc_pkg.sv -----
package blpc_pkg;

  typedef enum logic [3:0] {
    PH_TEXT   = 4'd0,
    PH_SECOND = 4'd1,
    PH_S_LO   = 4'd2,
    PH_S_HI   = 4'd3,
    PH_S2_LO  = 4'd4,
    PH_S2_HI  = 4'd5,
    PH_E_LO   = 4'd6,
    PH_E_HI   = 4'd7,
    PH_DATA   = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_BLOCK = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_HDR_EOF   = 2'd0;
  localparam logic [1:0] ERR_END_BELOW = 2'd1;
  localparam logic [1:0] ERR_SHORT     = 2'd2;

  localparam logic [7:0]  BYTE_MARK = 8'hFF;
  localparam logic [15:0] WORD_MARK = 16'hFFFF;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef struct packed {
    logic [1:0]  kind_res;
    logic [7:0]  text_byte;
    logic [15:0] load_first;
    logic [15:0] load_last;
    logic        has_marker;
    logic [31:0] block_crc;
    logic [1:0]  error_code;
  } res_t;

endpackage

// ----- src/blpc_in_if.sv -----
interface blpc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// ----- src/blpc_out_if.sv -----
interface blpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind_res;
  logic [7:0]  text_byte;
  logic [15:0] load_first;
  logic [15:0] load_last;
  logic        has_marker;
  logic [31:0] block_crc;
  logic [1:0]  error_code;

  modport source (
    output valid, output kind_res, output text_byte, output load_first,
    output load_last, output has_marker, output block_crc, output error_code,
    input ready
  );
  modport sink (
    input valid, input kind_res, input text_byte, input load_first,
    input load_last, input has_marker, input block_crc, input error_code,
    output ready
  );
endinterface

// ----- src/blpc_crc_byte.sv -----
module blpc_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);
  import blpc_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    // one reflected shift per data bit
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end
endmodule

// ----- src/binary_load_block_parser_crc.sv -----
// Binary load file parser with per-block CRC-32.
//
// in_ch carries one request per file byte (kind = 0, data_byte) or the
// end-of-file mark (kind = 1). Header text bytes come back as text results
// until an FF FF pair; then each block (optional FFFF marker, start word,
// end word, data) yields one block record with the reflected CRC-32 of its
// data. A clean end or an error record closes the file; later requests are
// taken and dropped.
//
// Throughput: one request per clock while in_ch.ready is high. Latency: a
// result appears on out_ch the cycle after its request is taken when the
// output register is free. The byte-wide CRC update sits between the state
// registers and the result register.
//
// A two-entry result queue (output register plus skid register) parts the
// channels: in_ch.ready drops only when both hold a result. While the
// receiver stalls, requests that produce no result keep flowing and one more
// result is parked in the skid register before in_ch.ready drops.
// Reset (rst_n low, synchronous) returns to the text phase and empties both
// result registers.
module binary_load_block_parser_crc (
  input  logic              clk,
  input  logic              rst_n,
  blpc_in_if.sink           in_ch,
  blpc_out_if.source        out_ch
);
  import blpc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] first_addr_r, first_addr_nxt;
  logic [15:0] last_addr_r, last_addr_nxt;
  logic [7:0]  low_half_r, low_half_nxt;
  logic [16:0] bytes_left_r, bytes_left_nxt;
  logic        marker_r, marker_nxt;
  logic [31:0] crc_r, crc_nxt;

  res_t        out_r, out_nxt;
  res_t        skid_r, skid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;

  logic        accept;
  logic        out_fire;
  logic        eof;
  logic [15:0] word;
  logic [16:0] span;
  logic [31:0] crc_step;
  logic        res_vld;
  res_t        res;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign eof      = in_ch.kind;
  assign word     = {in_ch.data_byte, low_half_r};
  assign span     = {1'b0, word} - {1'b0, first_addr_r} + 17'd1;

  blpc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (in_ch.data_byte),
    .crc_out (crc_step)
  );

  // parse step
  always_comb begin
    phase_nxt      = phase_r;
    first_addr_nxt = first_addr_r;
    last_addr_nxt  = last_addr_r;
    low_half_nxt   = low_half_r;
    bytes_left_nxt = bytes_left_r;
    marker_nxt     = marker_r;
    crc_nxt        = crc_r;
    res_vld        = 1'b0;
    res            = '0;
    if (accept) begin
      case (phase_r)
        PH_TEXT: begin
          if (eof) begin
            phase_nxt    = PH_DONE;
            res_vld      = 1'b1;
            res.kind_res = KIND_END;
          end else if (in_ch.data_byte == BYTE_MARK) begin
            phase_nxt = PH_SECOND;
          end else begin
            res_vld       = 1'b1;
            res.kind_res  = KIND_TEXT;
            res.text_byte = in_ch.data_byte;
          end
        end
        PH_SECOND: begin
          if (eof || in_ch.data_byte != BYTE_MARK) begin
            phase_nxt    = PH_DONE;
            res_vld      = 1'b1;
            res.kind_res = KIND_END;
          end else begin
            phase_nxt = PH_S_LO;
          end
        end
        PH_S_LO: begin
          if (eof) begin
            phase_nxt    = PH_DONE;
            res_vld      = 1'b1;
            res.kind_res = KIND_END;
          end else begin
            low_half_nxt = in_ch.data_byte;
            marker_nxt   = 1'b0;
            phase_nxt    = PH_S_HI;
          end
        end
        PH_S_HI, PH_S2_LO, PH_S2_HI, PH_E_LO, PH_E_HI: begin
          if (eof) begin
            phase_nxt      = PH_DONE;
            res_vld        = 1'b1;
            res.kind_res   = KIND_ERROR;
            res.error_code = ERR_HDR_EOF;
          end else begin
            case (phase_r)
              PH_S_HI: begin
                if (word == WORD_MARK) begin
                  marker_nxt = 1'b1;
                  phase_nxt  = PH_S2_LO;
                end else begin
                  first_addr_nxt = word;
                  phase_nxt      = PH_E_LO;
                end
              end
              PH_S2_LO: begin
                low_half_nxt = in_ch.data_byte;
                phase_nxt    = PH_S2_HI;
              end
              PH_S2_HI: begin
                first_addr_nxt = word;
                phase_nxt      = PH_E_LO;
              end
              PH_E_LO: begin
                low_half_nxt = in_ch.data_byte;
                phase_nxt    = PH_E_HI;
              end
              default: begin
                last_addr_nxt = word;
                if (word < first_addr_r) begin
                  phase_nxt      = PH_DONE;
                  res_vld        = 1'b1;
                  res.kind_res   = KIND_ERROR;
                  res.error_code = ERR_END_BELOW;
                end else begin
                  bytes_left_nxt = span;
                  crc_nxt        = CRC_INIT;
                  phase_nxt      = PH_DATA;
                end
              end
            endcase
          end
        end
        PH_DATA: begin
          if (eof) begin
            phase_nxt      = PH_DONE;
            res_vld        = 1'b1;
            res.kind_res   = KIND_ERROR;
            res.error_code = ERR_SHORT;
          end else begin
            crc_nxt        = crc_step;
            bytes_left_nxt = bytes_left_r - 17'd1;
            if (bytes_left_r == 17'd1) begin
              phase_nxt      = PH_S_LO;
              res_vld        = 1'b1;
              res.kind_res   = KIND_BLOCK;
              res.load_first = first_addr_r;
              res.load_last  = last_addr_r;
              res.has_marker = marker_r;
              res.block_crc  = crc_step ^ CRC_INIT;
            end
          end
        end
        default: begin
          // finished or meaningless phase: drop the request
        end
      endcase
    end
  end

  // result queue: output register with one skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_vld) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TEXT;
      first_addr_r <= '0;
      last_addr_r  <= '0;
      low_half_r   <= '0;
      bytes_left_r <= '0;
      marker_r     <= 1'b0;
      crc_r        <= CRC_INIT;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      first_addr_r <= first_addr_nxt;
      last_addr_r  <= last_addr_nxt;
      low_half_r   <= low_half_nxt;
      bytes_left_r <= bytes_left_nxt;
      marker_r     <= marker_nxt;
      crc_r        <= crc_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ch.ready        = !skid_valid_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind_res    = out_r.kind_res;
  assign out_ch.text_byte   = out_r.text_byte;
  assign out_ch.load_first  = out_r.load_first;
  assign out_ch.load_last   = out_r.load_last;
  assign out_ch.has_marker  = out_r.has_marker;
  assign out_ch.block_crc   = out_r.block_crc;
  assign out_ch.error_code  = out_r.error_code;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("parser left the finished phase");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bytes_left_r != 17'd0)
    else $error("data phase with no bytes left");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ch.ready))
    else $error("skid filled without a stalled output");
`endif

endmodule
